// ===== sv/dhcp_opt_pkg.sv =====
// Shared types and constants for the DHCP option extractor.
// Holds option codes, result kinds and the parser state structs.
// No dependencies.
package dhcp_opt_pkg;

  localparam logic [23:0] CookieHead = 24'h638253;
  localparam logic [7:0]  CookieLast = 8'h63;

  localparam logic [7:0] OptPad    = 8'h00;
  localparam logic [7:0] OptEnd    = 8'hFF;
  localparam logic [7:0] OptType   = 8'h35;
  localparam logic [7:0] OptClient = 8'h3d;
  localparam logic [7:0] OptLease  = 8'h33;
  localparam logic [7:0] OptServer = 8'h36;
  localparam logic [7:0] OptMask   = 8'h01;

  localparam logic [63:0] TypeDiscover = 64'd1;
  localparam logic [63:0] TypeOffer    = 64'd2;
  localparam logic [63:0] TypeRequest  = 64'd3;
  localparam logic [63:0] TypeAck      = 64'd5;

  localparam logic [2:0] KindNone     = 3'd0;
  localparam logic [2:0] KindDiscover = 3'd1;
  localparam logic [2:0] KindOffer    = 3'd2;
  localparam logic [2:0] KindRequest  = 3'd3;
  localparam logic [2:0] KindAck      = 3'd4;

  typedef struct packed {
    logic        type_seen;
    logic [63:0] type_value;
    logic        client_seen;
    logic [7:0]  client_hw_type;
    logic [47:0] client_mac;
    logic        lease_seen;
    logic [47:0] lease_value;
    logic        server_seen;
    logic [31:0] server_addr;
    logic        mask_seen;
    logic [31:0] mask_addr;
  } cap_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [23:0] recent_bytes;
    logic [7:0]  current_code;
    logic [7:0]  bytes_left;
    logic [7:0]  value_offset;
    cap_t        cap;
  } parse_st_t;

endpackage

// ===== sv/dhcp_option_extractor_core.sv =====
// Top level of the DHCP option extractor: stream ports around the parser
// and the result register. Depends on dhcp_opt_pkg, dhcp_opt_parser
// and dhcp_opt_result.
//
//  channel  | direction | tdata                          | tuser / tlast
//  ---------+-----------+--------------------------------+------------------------------
//  s_*      | in        | [7:0] data_byte                | tlast: last_byte
//  m_*      | out       | [7:0] hardware_type,           | tuser [2:0] message_kind,
//           |           | [55:8] option_value            |       [3] option_found
//
// One byte per cycle while the input is not stalled; a result appears in the cycle after the last byte of a
// message is taken, set by the single output register.
// Reset clears the parser to cookie search and empties the output register.
// The input stalls only while a result waits and m_tready_i is low.
module dhcp_option_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tlast_i,   // last_byte
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o,   // [7:0] hardware_type, [55:8] option_value
  output logic [3:0]  m_tuser_o    // [2:0] message_kind, [3] option_found
);
  import dhcp_opt_pkg::*;

  logic        accept;
  cap_t        cap;
  logic [2:0]  kind;
  logic        found;
  logic [7:0]  hw;
  logic [47:0] val;

  assign s_tready_o = !m_tvalid_o || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  dhcp_opt_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_tdata_i),
    .last_byte_i (s_tlast_i),
    .cap_o       (cap)
  );

  dhcp_opt_result u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept && s_tlast_i),
    .cap_i           (cap),
    .ready_i         (m_tready_i),
    .valid_o         (m_tvalid_o),
    .message_kind_o  (kind),
    .option_found_o  (found),
    .hardware_type_o (hw),
    .option_value_o  (val)
  );

  assign m_tdata_o = {val, hw};
  assign m_tuser_o = {found, kind};

endmodule

// ===== sv/dhcp_opt_parser.sv =====
// Byte-wise DHCP option parser: cookie search and option walk.
// Presents the captured options after the current byte.
// Depends on dhcp_opt_pkg.
module dhcp_opt_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output dhcp_opt_pkg::cap_t cap_o
);
  import dhcp_opt_pkg::*;

  localparam logic [2:0] PhCookie = 3'd0;
  localparam logic [2:0] PhCode   = 3'd1;
  localparam logic [2:0] PhLen    = 3'd2;
  localparam logic [2:0] PhValue  = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  parse_st_t st_q, st_d;
  logic [2:0] mac_idx;

  assign mac_idx = 3'(3'd6 - st_q.value_offset[2:0]);

  always_comb begin
    st_d = st_q;
    case (st_q.phase)
      PhCookie: begin
        if (st_q.recent_bytes == CookieHead && data_byte_i == CookieLast) begin
          st_d.phase = PhCode;
        end
        st_d.recent_bytes = {st_q.recent_bytes[15:0], data_byte_i};
      end
      PhCode: begin
        if (data_byte_i == OptEnd) begin
          st_d.phase = PhDone;
        end else if (data_byte_i != OptPad) begin
          st_d.current_code = data_byte_i;
          st_d.phase        = PhLen;
        end
      end
      PhLen: begin
        st_d.current_code = OptPad;
        case (st_q.current_code)
          OptType: if (!st_q.cap.type_seen) begin
            st_d.cap.type_seen  = 1'b1;
            st_d.cap.type_value = '0;
            st_d.current_code   = OptType;
          end
          OptClient: if (!st_q.cap.client_seen) begin
            st_d.cap.client_seen    = 1'b1;
            st_d.cap.client_hw_type = '0;
            st_d.cap.client_mac     = '0;
            st_d.current_code       = OptClient;
          end
          OptLease: if (!st_q.cap.lease_seen) begin
            st_d.cap.lease_seen  = 1'b1;
            st_d.cap.lease_value = '0;
            st_d.current_code    = OptLease;
          end
          OptServer: if (!st_q.cap.server_seen) begin
            st_d.cap.server_seen = 1'b1;
            st_d.cap.server_addr = '0;
            st_d.current_code    = OptServer;
          end
          OptMask: if (!st_q.cap.mask_seen) begin
            st_d.cap.mask_seen = 1'b1;
            st_d.cap.mask_addr = '0;
            st_d.current_code  = OptMask;
          end
          default: ;
        endcase
        st_d.bytes_left   = data_byte_i;
        st_d.value_offset = '0;
        st_d.phase        = (data_byte_i == 8'd0) ? PhCode : PhValue;
      end
      PhValue: begin
        case (st_q.current_code)
          OptType: st_d.cap.type_value = {st_q.cap.type_value[55:0], data_byte_i};
          OptClient: begin
            if (st_q.value_offset == 8'd0) begin
              st_d.cap.client_hw_type = data_byte_i;
            end else if (st_q.value_offset <= 8'd6) begin
              st_d.cap.client_mac[{mac_idx, 3'b000} +: 8] = data_byte_i;
            end
          end
          OptLease: begin
            if (|st_q.cap.lease_value[47:40]) begin
              st_d.cap.lease_value = '1;
            end else begin
              st_d.cap.lease_value = {st_q.cap.lease_value[39:0], data_byte_i};
            end
          end
          OptServer: if (st_q.value_offset < 8'd4) begin
            st_d.cap.server_addr[{~st_q.value_offset[1:0], 3'b000} +: 8] = data_byte_i;
          end
          OptMask: if (st_q.value_offset < 8'd4) begin
            st_d.cap.mask_addr[{~st_q.value_offset[1:0], 3'b000} +: 8] = data_byte_i;
          end
          default: ;
        endcase
        if (st_q.value_offset != 8'hFF) begin
          st_d.value_offset = st_q.value_offset + 8'd1;
        end
        st_d.bytes_left = st_q.bytes_left - 8'd1;
        if (st_q.bytes_left == 8'd1) begin
          st_d.phase = PhCode;
        end
      end
      default: ;
    endcase
  end

  // restart on the last byte of a message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= last_byte_i ? '0 : st_d;
    end
  end

  assign cap_o = st_d.cap;

endmodule

// ===== sv/dhcp_opt_result.sv =====
// Result decode and output register for the DHCP option extractor.
// Selects the value for the message kind and holds it until taken.
// Depends on dhcp_opt_pkg.
module dhcp_opt_result (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dhcp_opt_pkg::cap_t cap_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic [2:0]         message_kind_o,
  output logic               option_found_o,
  output logic [7:0]         hardware_type_o,
  output logic [47:0]        option_value_o
);
  import dhcp_opt_pkg::*;

  logic        valid_q;
  logic [2:0]  kind_d, kind_q;
  logic        found_d, found_q;
  logic [7:0]  hw_d, hw_q;
  logic [47:0] val_d, val_q;

  always_comb begin
    kind_d  = KindNone;
    found_d = 1'b0;
    hw_d    = '0;
    val_d   = '0;
    if (cap_i.type_seen) begin
      if (cap_i.type_value == TypeDiscover) begin
        kind_d = KindDiscover;
        if (cap_i.client_seen) begin
          found_d = 1'b1;
          hw_d    = cap_i.client_hw_type;
          val_d   = cap_i.client_mac;
        end
      end else if (cap_i.type_value == TypeOffer) begin
        kind_d = KindOffer;
        if (cap_i.lease_seen) begin
          found_d = 1'b1;
          val_d   = cap_i.lease_value;
        end
      end else if (cap_i.type_value == TypeRequest) begin
        kind_d = KindRequest;
        if (cap_i.server_seen) begin
          found_d = 1'b1;
          val_d   = {16'd0, cap_i.server_addr};
        end
      end else if (cap_i.type_value == TypeAck) begin
        kind_d = KindAck;
        if (cap_i.mask_seen) begin
          found_d = 1'b1;
          val_d   = {16'd0, cap_i.mask_addr};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q  <= kind_d;
      found_q <= found_d;
      hw_q    <= hw_d;
      val_q   <= val_d;
    end
  end

  assign valid_o         = valid_q;
  assign message_kind_o  = kind_q;
  assign option_found_o  = found_q;
  assign hardware_type_o = hw_q;
  assign option_value_o  = val_q;

endmodule

// ===== tb/tb_dhcp_option_extractor_core.sv =====
// Testbench for dhcp_option_extractor_core: streams DHCP messages byte by byte
// and checks random results against a built-in option parser predictor, directed ones against table values.
// Depends on dhcp_opt_pkg and the core RTL.
module tb_dhcp_option_extractor_core;
  import dhcp_opt_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic        found;
    logic [7:0]  hw;
    logic [47:0] val;
  } dhcp_result_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed;
    dhcp_result_t res;
  } dir_row_t;

  typedef enum logic [2:0] {
    PhCookie = 3'd0,
    PhCode   = 3'd1,
    PhLen    = 3'd2,
    PhValue  = 3'd3,
    PhDone   = 3'd4
  } parse_phase_e;

  localparam int RandomBytes = 1350;
  localparam int DirLen = 39;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam dhcp_result_t NoCheck = '0;

  localparam dir_row_t DirRows [DirLen] = '{
    '{OptEnd, 1'b1, 1'b1, '{KindNone, 1'b0, 8'h00, 48'h0}},
    // ack: pad, zero-length mask, end code, byte after end ignored
    '{8'h63, 1'b0, 1'b0, NoCheck},
    '{8'h82, 1'b0, 1'b0, NoCheck},
    '{8'h53, 1'b0, 1'b0, NoCheck},
    '{CookieLast, 1'b0, 1'b0, NoCheck},
    '{OptPad, 1'b0, 1'b0, NoCheck},
    '{OptType, 1'b0, 1'b0, NoCheck},
    '{8'h01, 1'b0, 1'b0, NoCheck},
    '{TypeAck[7:0], 1'b0, 1'b0, NoCheck},
    '{OptMask, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{OptEnd, 1'b0, 1'b0, NoCheck},
    '{OptType, 1'b1, 1'b1, '{KindAck, 1'b1, 8'h00, 48'h0}},
    // offer: seven lease bytes saturate
    '{8'h63, 1'b0, 1'b0, NoCheck},
    '{8'h82, 1'b0, 1'b0, NoCheck},
    '{8'h53, 1'b0, 1'b0, NoCheck},
    '{CookieLast, 1'b0, 1'b0, NoCheck},
    '{OptType, 1'b0, 1'b0, NoCheck},
    '{8'h01, 1'b0, 1'b0, NoCheck},
    '{TypeOffer[7:0], 1'b0, 1'b0, NoCheck},
    '{OptLease, 1'b0, 1'b0, NoCheck},
    '{8'h07, 1'b0, 1'b0, NoCheck},
    '{8'h01, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b0, 1'b0, NoCheck},
    '{8'h00, 1'b1, 1'b1, '{KindOffer, 1'b1, 8'h00, Max48}},
    // discover: client id carries only the hardware type
    '{8'h63, 1'b0, 1'b0, NoCheck},
    '{8'h82, 1'b0, 1'b0, NoCheck},
    '{8'h53, 1'b0, 1'b0, NoCheck},
    '{CookieLast, 1'b0, 1'b0, NoCheck},
    '{OptType, 1'b0, 1'b0, NoCheck},
    '{8'h01, 1'b0, 1'b0, NoCheck},
    '{TypeDiscover[7:0], 1'b0, 1'b0, NoCheck},
    '{OptClient, 1'b0, 1'b0, NoCheck},
    '{8'h01, 1'b0, 1'b0, NoCheck},
    '{8'h80, 1'b1, 1'b1, '{KindDiscover, 1'b1, 8'h80, 48'h0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;
  logic        s_tlast_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [55:0] m_tdata_o;
  logic [3:0]  m_tuser_o;

  dhcp_option_extractor_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  parse_phase_e phase_q;
  logic [23:0]  recent_q;
  logic [7:0]   code_q;
  logic [7:0]   left_q;
  logic [7:0]   offset_q;
  logic         type_seen_q, client_seen_q, lease_seen_q, server_seen_q, mask_seen_q;
  logic [63:0]  type_q;
  logic [7:0]   hw_type_q;
  logic [47:0]  mac_q;
  logic [47:0]  lease_q;
  logic [31:0]  server_q;
  logic [31:0]  mask_q;

  dhcp_result_t pending_results [$];
  logic [7:0]   msg_bytes [$];
  int unsigned  mismatch_count;
  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;
  int unsigned  sent_bytes;

  function automatic logic [31:0] put_addr(logic [31:0] addr, logic [7:0] off, logic [7:0] b);
    if (off < 8'd4) addr = addr | (32'(b) << ((3 - off) * 8));
    return addr;
  endfunction

  task automatic clear_parser();
    phase_q = PhCookie;
    recent_q = '0;
    code_q = '0;
    left_q = '0;
    offset_q = '0;
    type_seen_q = 1'b0;
    type_q = '0;
    client_seen_q = 1'b0;
    hw_type_q = '0;
    mac_q = '0;
    lease_seen_q = 1'b0;
    lease_q = '0;
    server_seen_q = 1'b0;
    server_q = '0;
    mask_seen_q = 1'b0;
    mask_q = '0;
  endtask

  task automatic open_capture();
    logic [7:0] code;
    code = code_q;
    code_q = '0;
    case (code)
      OptType:   if (!type_seen_q) begin
        type_seen_q = 1'b1; type_q = '0; code_q = code;
      end
      OptClient: if (!client_seen_q) begin
        client_seen_q = 1'b1; hw_type_q = '0; mac_q = '0; code_q = code;
      end
      OptLease:  if (!lease_seen_q) begin
        lease_seen_q = 1'b1; lease_q = '0; code_q = code;
      end
      OptServer: if (!server_seen_q) begin
        server_seen_q = 1'b1; server_q = '0; code_q = code;
      end
      OptMask:   if (!mask_seen_q) begin
        mask_seen_q = 1'b1; mask_q = '0; code_q = code;
      end
      default: ;
    endcase
  endtask

  task automatic capture_value(logic [7:0] b);
    case (code_q)
      OptType: type_q = {type_q[55:0], b};
      OptClient: begin
        if (offset_q == 8'd0) hw_type_q = b;
        else if (offset_q <= 8'd6) mac_q = mac_q | (48'(b) << ((6 - offset_q) * 8));
      end
      OptLease: begin
        if (lease_q > (Max48 >> 8)) lease_q = Max48;
        else lease_q = {lease_q[39:0], b};
      end
      OptServer: server_q = put_addr(server_q, offset_q, b);
      OptMask: mask_q = put_addr(mask_q, offset_q, b);
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit has_res, output dhcp_result_t res);
    case (phase_q)
      PhCookie: begin
        if (recent_q == CookieHead && b == CookieLast) phase_q = PhCode;
        recent_q = {recent_q[15:0], b};
      end
      PhCode: begin
        if (b == OptEnd) phase_q = PhDone;
        else if (b != OptPad) begin
          code_q = b;
          phase_q = PhLen;
        end
      end
      PhLen: begin
        open_capture();
        left_q = b;
        offset_q = '0;
        phase_q = (b == 8'd0) ? PhCode : PhValue;
      end
      PhValue: begin
        capture_value(b);
        if (offset_q != 8'hFF) offset_q++;
        left_q--;
        if (left_q == 8'd0) phase_q = PhCode;
      end
      default: ;
    endcase
    has_res = last;
    res = '0;
    if (!last) return;
    if (type_seen_q) begin
      if (type_q == TypeDiscover) begin
        res.kind = KindDiscover;
        if (client_seen_q) begin
          res.found = 1'b1; res.hw = hw_type_q; res.val = mac_q;
        end
      end else if (type_q == TypeOffer) begin
        res.kind = KindOffer;
        if (lease_seen_q) begin
          res.found = 1'b1; res.val = lease_q;
        end
      end else if (type_q == TypeRequest) begin
        res.kind = KindRequest;
        if (server_seen_q) begin
          res.found = 1'b1; res.val = 48'(server_q);
        end
      end else if (type_q == TypeAck) begin
        res.kind = KindAck;
        if (mask_seen_q) begin
          res.found = 1'b1; res.val = 48'(mask_q);
        end
      end
    end
    clear_parser();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input dhcp_result_t typed_res);
    bit           has_res;
    dhcp_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    parse_byte(b, last, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
    s_tvalid_i <= 1'b1;
    s_tdata_i <= b;
    s_tlast_i <= last;
    do @(posedge clk_i); while (!s_tready_o);
    sent_bytes++;
  endtask

  function automatic int pick_len(int typical);
    int r;
    r = $urandom_range(99);
    if (r < 65) return typical;
    if (r < 77) return 0;
    if (r < 99) return $urandom_range(1, 10);
    return $urandom_range(200, 255);
  endfunction

  task automatic push_option(logic [7:0] code, int len);
    msg_bytes.push_back(code);
    msg_bytes.push_back(8'(len));
    repeat (len) msg_bytes.push_back(8'($urandom));
  endtask

  task automatic build_message();
    int n_opts;
    int type_pos;
    int len;
    int cut;
    msg_bytes.delete();
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
    msg_bytes.push_back(8'h63);
    msg_bytes.push_back(8'h82);
    msg_bytes.push_back(8'h53);
    msg_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : CookieLast);
    n_opts = $urandom_range(0, 6);
    type_pos = ($urandom_range(99) < 88) ? $urandom_range(0, n_opts) : -1;
    for (int i = 0; i <= n_opts; i++) begin
      if (i == type_pos) begin
        len = pick_len(1);
        if (len == 1) begin
          msg_bytes.push_back(OptType);
          msg_bytes.push_back(8'd1);
          case ($urandom_range(5))
            0: msg_bytes.push_back(TypeDiscover[7:0]);
            1: msg_bytes.push_back(TypeOffer[7:0]);
            2: msg_bytes.push_back(TypeRequest[7:0]);
            3: msg_bytes.push_back(TypeAck[7:0]);
            default: msg_bytes.push_back(8'($urandom));
          endcase
        end else begin
          push_option(OptType, len);
        end
      end
      if (i == n_opts) break;
      case ($urandom_range(9))
        0: msg_bytes.push_back(OptPad);
        1, 2: push_option(OptClient, pick_len(7));
        3: push_option(OptLease, pick_len(4));
        4: push_option(OptServer, pick_len(4));
        5: push_option(OptMask, pick_len(4));
        6: push_option(OptType, pick_len(1));
        7: push_option(8'($urandom), $urandom_range(0, 5));
        8: begin
          msg_bytes.push_back(OptEnd);
          repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
        end
        default: push_option(OptServer, 4);
      endcase
    end
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 200000);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    dhcp_result_t got;
    dhcp_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{m_tuser_o[2:0], m_tuser_o[3], m_tdata_o[7:0], m_tdata_o[55:8]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d found=%0d hw=%h value=%h",
                 $time, got.kind, got.found, got.hw, got.val);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display({"%0t: expected kind=%0d found=%0d hw=%h value=%h, ",
                    "got kind=%0d found=%0d hw=%h value=%h"},
                   $time, want.kind, want.found, want.hw, want.val,
                   got.kind, got.found, got.hw, got.val);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    sent_bytes = 0;
    clear_parser();
    rst_ni <= 1'b0;
    s_tvalid_i <= 1'b0;
    s_tdata_i <= 8'h00;
    s_tlast_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirLen; i++) begin
      send_byte(DirRows[i].data, DirRows[i].last, DirRows[i].typed, DirRows[i].res);
    end

    sent_bytes = 0;
    while (sent_bytes < RandomBytes) begin
      case (sent_bytes * 5 / RandomBytes)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
        3: begin src_idle_pct = 32; sink_stall_pct = 32; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      build_message();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, NoCheck);
    end

    s_tvalid_i <= 1'b0;
    sink_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
